// ===== src/hvg_pkg.sv =====
// ----------------------------------------------------------------------------
// hvg_pkg
// Shared widths, latencies, types and tables of the hypersphere vertex generator.
// ----------------------------------------------------------------------------
package hvg_pkg;

  localparam int STEP_BITS     = 10;
  localparam int COORD_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  // angles are binary turns, 2^32 = full circle
  localparam int ANGLE_BITS = 32;
  localparam int QUO_BITS   = ANGLE_BITS + 1;
  localparam int DIV_STAGES = STEP_BITS + ANGLE_BITS;
  localparam int CORD_LAT   = CORDIC_STAGES + 2;
  localparam int BACK_LAT   = DIV_STAGES + CORD_LAT + 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int REG_BITS = 2;
  localparam logic [REG_BITS-1:0] REG_PHI_COUNT   = 2'd0;
  localparam logic [REG_BITS-1:0] REG_THETA_COUNT = 2'd1;
  localparam logic [REG_BITS-1:0] REG_PSI_COUNT   = 2'd2;

  localparam logic [STEP_BITS-1:0] PHI_COUNT_RESET   = STEP_BITS'(16);
  localparam logic [STEP_BITS-1:0] THETA_COUNT_RESET = STEP_BITS'(16);
  localparam logic [STEP_BITS-1:0] PSI_COUNT_RESET   = STEP_BITS'(32);

  typedef logic [STEP_BITS-1:0] step_t;
  typedef logic signed [31:0] q30_t;

  typedef struct packed {
    step_t phi;
    step_t theta;
    step_t psi;
  } counts_t;

  typedef struct packed {
    step_t phi;
    step_t theta;
    step_t psi;
    logic  pole;
    logic  out_range;
  } item_t;

  localparam logic [31:0] ATAN_TURNS [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

endpackage

// ===== src/hvg_front.sv =====
// ----------------------------------------------------------------------------
// hvg_front
// Clamps the phi and theta steps to the grid and flags range errors and poles.
// ----------------------------------------------------------------------------
module hvg_front
  import hvg_pkg::*;
(
  input  counts_t counts,
  input  step_t   phi_step,
  input  step_t   theta_step,
  input  step_t   psi_step,
  output item_t   item
);

  logic phi_over;
  logic theta_over;
  logic psi_over;

  always_comb begin
    phi_over   = phi_step > counts.phi;
    theta_over = theta_step > counts.theta;
    psi_over   = psi_step >= counts.psi;
    item.phi   = phi_over ? counts.phi : phi_step;
    item.theta = theta_over ? counts.theta : theta_step;
    // psi wraps by itself in the division
    item.psi       = psi_step;
    item.pole      = (item.phi == '0) || (item.phi == counts.phi);
    item.out_range = phi_over || theta_over || psi_over;
  end

endmodule

// ===== src/hvg_fifo.sv =====
// ----------------------------------------------------------------------------
// hvg_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module hvg_fifo
  import hvg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  not_empty,
  input  logic  pop,
  output item_t head
);

  item_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;

  assign full      = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/hvg_div.sv =====
// ----------------------------------------------------------------------------
// hvg_div
// Pipelined restoring divider: floor(num * 2^32 / den), one quotient bit a stage.
// ----------------------------------------------------------------------------
module hvg_div
  import hvg_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  step_t               num,
  input  step_t               den,
  output logic [QUO_BITS-1:0] quo
);

  step_t               rem_q  [DIV_STAGES];
  step_t               num_q  [DIV_STAGES];
  logic [QUO_BITS-1:0] quo_q  [DIV_STAGES];
  step_t               rem_d  [DIV_STAGES];
  step_t               num_d  [DIV_STAGES];
  logic [QUO_BITS-1:0] quo_d  [DIV_STAGES];

  always_comb begin
    logic [STEP_BITS:0]   t;
    logic [STEP_BITS:0]   diff;
    step_t                r_prev;
    step_t                n_prev;
    logic [QUO_BITS-1:0]  q_prev;
    logic                 ge;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        r_prev = '0;
        n_prev = num;
        q_prev = '0;
      end else begin
        r_prev = rem_q[s-1];
        n_prev = num_q[s-1];
        q_prev = quo_q[s-1];
      end
      t    = {r_prev, n_prev[STEP_BITS-1]};
      diff = t - {1'b0, den};
      ge   = t >= {1'b0, den};
      rem_d[s] = ge ? diff[STEP_BITS-1:0] : t[STEP_BITS-1:0];
      num_d[s] = {n_prev[STEP_BITS-2:0], 1'b0};
      quo_d[s] = {q_prev[QUO_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= num_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

// ===== src/hvg_cordic.sv =====
// ----------------------------------------------------------------------------
// hvg_cordic
// Pipelined rotation CORDIC giving Q30 cosine and sine of a binary-turn angle.
// ----------------------------------------------------------------------------
module hvg_cordic
  import hvg_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output q30_t                  cos_val,
  output q30_t                  sin_val
);

  localparam int CW = 34;
  localparam logic signed [CW-1:0] QTR  = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF = CW'(64'sd2147483648);

  logic signed [CW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] z_q [CORDIC_STAGES+1];
  logic                 flip_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] x_d [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_d [CORDIC_STAGES+1];
  logic signed [CW-1:0] z_d [CORDIC_STAGES+1];
  logic                 flip_d [CORDIC_STAGES+1];
  logic signed [CW-1:0] neg_x;
  logic signed [CW-1:0] neg_y;

  always_comb begin
    logic signed [CW-1:0] za;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    // fold into the right half plane, negate at the end
    za = {{(CW-ANGLE_BITS){angle[ANGLE_BITS-1]}}, angle};
    x_d[0]    = CW'(GAIN_Q30);
    y_d[0]    = '0;
    flip_d[0] = 1'b0;
    z_d[0]    = za;
    if (za > QTR) begin
      z_d[0]    = za - HALF;
      flip_d[0] = 1'b1;
    end else if (za < -QTR) begin
      z_d[0]    = za + HALF;
      flip_d[0] = 1'b1;
    end
    for (int s = 1; s <= CORDIC_STAGES; s++) begin
      dx = y_q[s-1] >>> (s-1);
      dy = x_q[s-1] >>> (s-1);
      at = {{(CW-32){1'b0}}, ATAN_TURNS[s-1]};
      flip_d[s] = flip_q[s-1];
      if (z_q[s-1] >= 0) begin
        x_d[s] = x_q[s-1] - dx;
        y_d[s] = y_q[s-1] + dy;
        z_d[s] = z_q[s-1] - at;
      end else begin
        x_d[s] = x_q[s-1] + dx;
        y_d[s] = y_q[s-1] - dy;
        z_d[s] = z_q[s-1] + at;
      end
    end
    neg_x = -x_q[CORDIC_STAGES];
    neg_y = -y_q[CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s <= CORDIC_STAGES; s++) begin
        x_q[s]    <= x_d[s];
        y_q[s]    <= y_d[s];
        z_q[s]    <= z_d[s];
        flip_q[s] <= flip_d[s];
      end
      cos_val <= flip_q[CORDIC_STAGES] ? neg_x[31:0] : x_q[CORDIC_STAGES][31:0];
      sin_val <= flip_q[CORDIC_STAGES] ? neg_y[31:0] : y_q[CORDIC_STAGES][31:0];
    end
  end

endmodule

// ===== src/hvg_back.sv =====
// ----------------------------------------------------------------------------
// hvg_back
// Angle division, sine and cosine, products and output formatting.
// ----------------------------------------------------------------------------
module hvg_back
  import hvg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  counts_t                      counts,
  input  logic                         head_valid,
  input  item_t                        head,
  output logic                         pop,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic signed [COORD_BITS-1:0] pos_z,
  output logic signed [COORD_BITS-1:0] pos_w,
  output logic        [COORD_BITS-1:0] color_r,
  output logic        [COORD_BITS-1:0] color_g,
  output logic        [COORD_BITS-1:0] color_b,
  output logic                         pole_flag,
  output logic                         range_flag
);

  localparam int SH_POS = 30 - (COORD_BITS - 1);
  localparam int SH_COL = 31 - COORD_BITS;

  typedef struct packed {
    logic valid;
    logic pole;
    logic out_range;
  } side_t;

  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = a * b;
    return p[61:30];
  endfunction

  function automatic logic [COORD_BITS-1:0] pos_fmt(input q30_t v);
    logic signed [32:0] t;
    logic signed [32:0] r;
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = (33'sd1 <<< (COORD_BITS - 1)) - 33'sd1;
    lo = -(33'sd1 <<< (COORD_BITS - 1));
    t  = {v[31], v} + (33'sd1 <<< (SH_POS - 1));
    r  = t >>> SH_POS;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] col_fmt(input q30_t d);
    logic signed [33:0] t;
    logic signed [33:0] r;
    logic signed [33:0] hi;
    hi = (34'sd1 <<< COORD_BITS) - 34'sd1;
    t  = {{2{d[31]}}, d} + (34'sd1 <<< 30) + (34'sd1 <<< (SH_COL - 1));
    r  = t >>> SH_COL;
    if (r > hi) begin
      r = hi;
    end else if (r < 0) begin
      r = '0;
    end
    return r[COORD_BITS-1:0];
  endfunction

  logic en;
  side_t side_q [BACK_LAT];

  logic [QUO_BITS-1:0] phi_quo;
  logic [QUO_BITS-1:0] theta_quo;
  logic [QUO_BITS-1:0] psi_quo;
  q30_t cp, sp, ct, st, cs, ss;

  // first product stage
  q30_t m1_sst, m1_z, m1_dx, m1_dy, m1_cp, m1_ct, m1_cs, m1_ss;
  // second product stage
  q30_t m2_x, m2_y, m2_z, m2_w, m2_dx, m2_dy, m2_dz;

  // the whole pipe moves unless a finished result is held
  assign en  = !out_valid || !out_stall;
  assign pop = en && head_valid;

  hvg_div u_div_phi (
    .clk (clk), .en (en), .num (head.phi), .den (counts.phi), .quo (phi_quo)
  );
  hvg_div u_div_theta (
    .clk (clk), .en (en), .num (head.theta), .den (counts.theta), .quo (theta_quo)
  );
  hvg_div u_div_psi (
    .clk (clk), .en (en), .num (head.psi), .den (counts.psi), .quo (psi_quo)
  );

  hvg_cordic u_cordic_phi (
    .clk (clk), .en (en), .angle (phi_quo[ANGLE_BITS:1]), .cos_val (cp), .sin_val (sp)
  );
  hvg_cordic u_cordic_theta (
    .clk (clk), .en (en), .angle (theta_quo[ANGLE_BITS:1]), .cos_val (ct), .sin_val (st)
  );
  hvg_cordic u_cordic_psi (
    .clk (clk), .en (en), .angle (psi_quo[ANGLE_BITS-1:0]), .cos_val (cs), .sin_val (ss)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < BACK_LAT; s++) begin
        side_q[s] <= '0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      side_q[0] <= '{valid: head_valid, pole: head.pole, out_range: head.out_range};
      for (int s = 1; s < BACK_LAT; s++) begin
        side_q[s] <= side_q[s-1];
      end
      out_valid <= side_q[BACK_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_sst <= mul_q30(sp, st);
      m1_z   <= mul_q30(sp, ct);
      m1_dx  <= mul_q30(st, cs);
      m1_dy  <= mul_q30(st, ss);
      m1_cp  <= cp;
      m1_ct  <= ct;
      m1_cs  <= cs;
      m1_ss  <= ss;

      m2_x  <= mul_q30(m1_sst, m1_cs);
      m2_y  <= mul_q30(m1_sst, m1_ss);
      m2_z  <= m1_z;
      m2_w  <= m1_cp;
      m2_dx <= m1_dx;
      m2_dy <= m1_dy;
      m2_dz <= m1_ct;

      pos_x      <= pos_fmt(m2_x);
      pos_y      <= pos_fmt(m2_y);
      pos_z      <= pos_fmt(m2_z);
      pos_w      <= pos_fmt(m2_w);
      color_r    <= col_fmt(m2_dx);
      color_g    <= col_fmt(m2_dy);
      color_b    <= col_fmt(m2_dz);
      pole_flag  <= side_q[BACK_LAT-1].pole;
      range_flag <= side_q[BACK_LAT-1].out_range;
    end
  end

endmodule

// ===== src/hypersphere_vertex_generator_top.sv =====
// ----------------------------------------------------------------------------
// hypersphere_vertex_generator_top
// Maps (phi, theta, psi) grid steps to a unit 3-sphere point and a color.
// ----------------------------------------------------------------------------
// One vertex per clock: a new request is taken every cycle while the request
// queue is not full and, with the output side never stalling, a result leaves
// every cycle. An accepted request passes through the request queue, 42
// divider stages that produce one angle bit each, the CORDIC pipeline, two
// product stages and the output register, in that order. A four-deep request
// queue sits between the range check and the arithmetic pipe, so input
// requests keep flowing while a finished result waits at the output, until
// the queue is full. Write the count registers only while the block is empty;
// a count of zero acts as one.
// pos_* are signed Q1.15, color_* unsigned Q0.16 saturated; pole_flag marks
// phi at zero or pi, range_flag marks a step outside the configured grid.
// ----------------------------------------------------------------------------
module hypersphere_vertex_generator_top
  import hvg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [REG_BITS-1:0]          cfg_index,
  input  logic [STEP_BITS-1:0]         cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [STEP_BITS-1:0]         phi_step,
  input  logic [STEP_BITS-1:0]         theta_step,
  input  logic [STEP_BITS-1:0]         psi_step,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic signed [COORD_BITS-1:0] pos_z,
  output logic signed [COORD_BITS-1:0] pos_w,
  output logic        [COORD_BITS-1:0] color_r,
  output logic        [COORD_BITS-1:0] color_g,
  output logic        [COORD_BITS-1:0] color_b,
  output logic                         pole_flag,
  output logic                         range_flag
);

  step_t   phi_count;
  step_t   theta_count;
  step_t   psi_count;
  counts_t counts;
  item_t   front_item;
  item_t   head;
  logic    fifo_full;
  logic    head_valid;
  logic    pop;
  logic    push;

  // count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phi_count   <= PHI_COUNT_RESET;
      theta_count <= THETA_COUNT_RESET;
      psi_count   <= PSI_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PHI_COUNT:   phi_count   <= cfg_data;
        REG_THETA_COUNT: theta_count <= cfg_data;
        REG_PSI_COUNT:   psi_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // treat a zero count as one
  always_comb begin
    counts.phi   = (phi_count == '0) ? STEP_BITS'(1) : phi_count;
    counts.theta = (theta_count == '0) ? STEP_BITS'(1) : theta_count;
    counts.psi   = (psi_count == '0) ? STEP_BITS'(1) : psi_count;
  end

  // hold the input side only when the request queue is full
  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  hvg_front u_front (
    .counts     (counts),
    .phi_step   (phi_step),
    .theta_step (theta_step),
    .psi_step   (psi_step),
    .item       (front_item)
  );

  hvg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (fifo_full),
    .not_empty (head_valid),
    .pop       (pop),
    .head      (head)
  );

  hvg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .counts     (counts),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .pos_w      (pos_w),
    .color_r    (color_r),
    .color_g    (color_g),
    .color_b    (color_b),
    .pole_flag  (pole_flag),
    .range_flag (range_flag)
  );

endmodule

// ===== tb/sv/hvg_vertex_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hvg_vertex_checker
// Watches the request and result channels of the vertex generator, predicts
// each vertex from the grid step and the count registers, and compares it.
// ----------------------------------------------------------------------------
module hvg_vertex_checker
  import hvg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [REG_BITS-1:0]          cfg_index,
  input  logic [STEP_BITS-1:0]         cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [STEP_BITS-1:0]         phi_step,
  input  logic [STEP_BITS-1:0]         theta_step,
  input  logic [STEP_BITS-1:0]         psi_step,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic signed [COORD_BITS-1:0] pos_w,
  input  logic        [COORD_BITS-1:0] color_r,
  input  logic        [COORD_BITS-1:0] color_g,
  input  logic        [COORD_BITS-1:0] color_b,
  input  logic                         pole_flag,
  input  logic                         range_flag,
  output int                           errors,
  output int                           pending,
  output int                           vertices_seen,
  output int                           poles_seen,
  output int                           ranges_seen
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x, y, z, w;
    logic [COORD_BITS-1:0]        r, g, b;
    logic                         pole, oor;
  } vertex_t;

  vertex_t vertex_queue[$];
  step_t   n_phi, n_theta, n_psi;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // rotation CORDIC on a 32-bit turn angle, result Q30
  function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(ang);
    x = longint'(GAIN_Q30);
    y = 0;
    flip = 0;
    if (ang[31]) z -= 64'sh1_0000_0000;
    if (z > 64'sh4000_0000) begin
      z -= 64'sh8000_0000; flip = 1;
    end else if (z < -64'sh4000_0000) begin
      z += 64'sh8000_0000; flip = 1;
    end
    for (int k = 0; k < CORDIC_STAGES && k < 30; k++) begin
      dx = fshr(y, k);
      dy = fshr(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [COORD_BITS-1:0] to_pos(longint v);
    longint r, hi;
    r = fshr(v + (64'sd1 <<< (30 - COORD_BITS)), 31 - COORD_BITS);
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] to_color(longint d);
    longint r, hi;
    r = fshr(d + (64'sd1 <<< 30) + (64'sd1 <<< (30 - COORD_BITS)), 31 - COORD_BITS);
    hi = (64'sd1 <<< COORD_BITS) - 1;
    if (r > hi) r = hi;
    if (r < 0) r = 0;
    return r[COORD_BITS-1:0];
  endfunction

  function automatic vertex_t predict_vertex(step_t i_in, step_t j_in, step_t k_in);
    longint unsigned np, nt, ns, i, j, k;
    longint cp, sp, ct, st, cs, ss, sst;
    vertex_t v;
    np = (n_phi == 0) ? 1 : n_phi;
    nt = (n_theta == 0) ? 1 : n_theta;
    ns = (n_psi == 0) ? 1 : n_psi;
    i = i_in; j = j_in; k = k_in;
    v.oor = (i > np) || (j > nt) || (k >= ns);
    if (i > np) i = np;
    if (j > nt) j = nt;
    rotate(32'((i << 31) / np), cp, sp);
    rotate(32'((j << 31) / nt), ct, st);
    rotate(32'((k << 32) / ns), cs, ss);
    sst = fshr(sp * st, 30);
    v.x = to_pos(fshr(sst * cs, 30));
    v.y = to_pos(fshr(sst * ss, 30));
    v.z = to_pos(fshr(sp * ct, 30));
    v.w = to_pos(cp);
    v.r = to_color(fshr(st * cs, 30));
    v.g = to_color(fshr(st * ss, 30));
    v.b = to_color(ct);
    v.pole = (i == 0) || (i == np);
    return v;
  endfunction

  assign pending = vertex_queue.size();

  always @(posedge clk) begin
    vertex_t got, want;
    if (rst) begin
      n_phi <= PHI_COUNT_RESET;
      n_theta <= THETA_COUNT_RESET;
      n_psi <= PSI_COUNT_RESET;
      vertex_queue.delete();
      errors <= 0;
      vertices_seen <= 0;
      poles_seen <= 0;
      ranges_seen <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PHI_COUNT: n_phi <= cfg_data;
          REG_THETA_COUNT: n_theta <= cfg_data;
          REG_PSI_COUNT: n_psi <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        vertex_queue.insert(vertex_queue.size(),
                            predict_vertex(phi_step, theta_step, psi_step));
      if (out_valid && !out_stall) begin
        got = '{pos_x, pos_y, pos_z, pos_w, color_r, color_g, color_b, pole_flag, range_flag};
        vertices_seen <= vertices_seen + 1;
        if (vertex_queue.size() == 0) begin
          $display("%0t: unexpected vertex %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = vertex_queue.pop_front();
          poles_seen <= poles_seen + want.pole;
          ranges_seen <= ranges_seen + want.oor;
          if (got !== want) begin
            $display("%0t: vertex mismatch expected x=%0d y=%0d z=%0d w=%0d rgb=%h/%h/%h p=%b o=%b",
                     $time, want.x, want.y, want.z, want.w, want.r, want.g, want.b,
                     want.pole, want.oor);
            $display("%0t:                 actual x=%0d y=%0d z=%0d w=%0d rgb=%h/%h/%h p=%b o=%b",
                     $time, got.x, got.y, got.z, got.w, got.r, got.g, got.b,
                     got.pole, got.oor);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/hypersphere_vertex_generator_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hypersphere_vertex_generator_top_test
// Drives grid steps through the vertex generator under several count settings
// with random gaps and back pressure; a checker module judges each vertex.
// ----------------------------------------------------------------------------
module hypersphere_vertex_generator_top_test;
  import hvg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [REG_BITS-1:0] cfg_index = REG_PHI_COUNT;
  logic [STEP_BITS-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [STEP_BITS-1:0] phi_step = '0, theta_step = '0, psi_step = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z, pos_w;
  logic [COORD_BITS-1:0] color_r, color_g, color_b;
  logic pole_flag, range_flag;

  int errors, pending, vertices_seen, poles_seen, ranges_seen;
  int cycle_count = 0;
  bit calm = 0;           // no idling on either side while set
  step_t cur_phi = 16, cur_theta = 16, cur_psi = 32;

  always #5 clk = ~clk;

  hypersphere_vertex_generator_top dut (.*);

  hvg_vertex_checker checker_i (.*);

  // random back pressure on the result side
  always @(negedge clk)
    out_stall <= !calm && ($urandom_range(99) < 22);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_count(logic [REG_BITS-1:0] idx, step_t val);
    @(negedge clk);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    case (idx)
      REG_PHI_COUNT: cur_phi = val;
      REG_THETA_COUNT: cur_theta = val;
      default: cur_psi = val;
    endcase
  endtask

  // hold a request until the block takes it; called at a falling edge
  task automatic send_request(step_t i, step_t j, step_t k);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; phi_step <= i; theta_step <= j; psi_step <= k;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drain and then reprogram all three counts
  task automatic set_grid(step_t p, step_t t, step_t s);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_count(REG_PHI_COUNT, p);
    write_count(REG_THETA_COUNT, t);
    write_count(REG_PSI_COUNT, s);
  endtask

  // mostly in-grid steps, sometimes any value the field holds
  task automatic send_random();
    step_t i, j, k;
    step_t np, nt, ns;
    np = (cur_phi == '0) ? step_t'(1) : cur_phi;
    nt = (cur_theta == '0) ? step_t'(1) : cur_theta;
    ns = (cur_psi == '0) ? step_t'(1) : cur_psi;
    if ($urandom_range(9) == 0) begin
      i = step_t'($urandom); j = step_t'($urandom); k = step_t'($urandom);
    end else begin
      i = step_t'($urandom_range(np));
      j = step_t'($urandom_range(nt));
      k = step_t'($urandom_range(ns - step_t'(1)));
      if ($urandom_range(7) == 0) i = ($urandom_range(1) != 0) ? '0 : np;
    end
    send_request(i, j, k);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: poles, equator, field extremes at reset counts
    send_request(0, 0, 0);
    send_request(16, 16, 31);
    send_request(8, 8, 8);
    send_request(8, 0, 16);
    send_request(4, 12, 24);
    send_request(1023, 1023, 1023);   // all three clamped or wrapped
    send_request(17, 3, 5);
    send_request(3, 17, 5);
    send_request(3, 3, 32);
    send_request(10'h2AA, 10'h155, 10'h2AA);
    send_request(10'h155, 10'h2AA, 10'h155);
    // zero counts act as one
    set_grid(0, 0, 0);
    send_request(0, 0, 0);
    send_request(1, 1, 0);
    send_request(2, 2, 1);
    send_request(1, 0, 0);
    // largest counts
    set_grid(1023, 1023, 1023);
    send_request(1023, 1023, 1022);
    send_request(511, 512, 511);
    send_request(1, 1, 1);
    send_request(1022, 1, 1023);
    set_grid(1, 1, 1);
    send_request(1, 1, 0);
    send_request(0, 1, 0);

    // random phases across several grids, one calm stretch on the second grid
    set_grid(16, 16, 32);
    repeat (90) send_random();
    set_grid(7, 5, 3);
    calm = 1;
    repeat (90) send_random();
    calm = 0;
    set_grid(1023, 1023, 1023);
    repeat (90) send_random();
    set_grid(step_t'($urandom_range(1, 1023)), step_t'($urandom_range(1, 1023)),
             step_t'($urandom_range(1, 1023)));
    repeat (90) send_random();
    set_grid(1, 2, 4);
    repeat (90) send_random();
    in_valid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d vertices over several grid settings: %0d at a pole, %0d off the grid.",
             vertices_seen, poles_seen, ranges_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
